// ===== hw/rtl/caot_pkg.sv =====
package caot_pkg;

  // Fixed timing constants of a button channel, in milliseconds.
  localparam logic [31:0] ButtonHoldMs  = 32'd14400000;
  localparam logic [31:0] ButtonGraceMs = 32'd300000;

  // Calendar constants for the firing days.
  localparam logic [4:0] SecondDayOfMonth = 5'd15;
  localparam logic [4:0] FirstDayOfMonth  = 5'd1;
  localparam logic [2:0] SecondWeekday    = 3'd3;
  localparam logic [2:0] Sunday           = 3'd0;

  // Configuration port geometry.
  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DataWidth = 32;

  typedef enum logic [2:0] {
    MODE_NONE          = 3'd0,
    MODE_ALWAYS_ON     = 3'd1,
    MODE_DAILY         = 3'd2,
    MODE_WEEKLY        = 3'd3,
    MODE_TWICE_DAILY   = 3'd4,
    MODE_TWICE_WEEKLY  = 3'd5,
    MODE_MONTHLY       = 3'd6,
    MODE_TWICE_MONTHLY = 3'd7
  } mode_e;

  typedef enum logic [0:0] {
    OP_TICK   = 1'b0,
    OP_TOGGLE = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    REG_CHANNEL_MODE   = 3'd0,
    REG_FIRST_HOUR     = 3'd1,
    REG_FIRST_MINUTE   = 3'd2,
    REG_SECOND_HOUR    = 3'd3,
    REG_SECOND_MINUTE  = 3'd4,
    REG_ON_DURATION_MS = 3'd5,
    REG_BUTTON_OUTPUT  = 3'd6,
    REG_UNUSED         = 3'd7
  } reg_idx_e;

  typedef struct packed {
    opcode_e     opcode;
    logic [31:0] now_ms;
    logic [2:0]  weekday;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } in_item_t;

  typedef struct packed {
    logic level_out;
    logic button_pulse;
    logic channel_running;
  } out_item_t;

  typedef struct packed {
    mode_e       channel_mode;
    logic [4:0]  first_hour;
    logic [5:0]  first_minute;
    logic [4:0]  second_hour;
    logic [5:0]  second_minute;
    logic [26:0] on_duration_ms;
    logic        button_output;
  } cfg_t;

endpackage

// ===== hw/rtl/caot_regs.sv =====
module caot_regs import caot_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[AddrWidth-1:2]);
  assign wr_en  = psel && penable && pwrite;

  // Register write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_CHANNEL_MODE:   cfg_d.channel_mode   = mode_e'(pwdata[2:0]);
        REG_FIRST_HOUR:     cfg_d.first_hour     = pwdata[4:0];
        REG_FIRST_MINUTE:   cfg_d.first_minute   = pwdata[5:0];
        REG_SECOND_HOUR:    cfg_d.second_hour    = pwdata[4:0];
        REG_SECOND_MINUTE:  cfg_d.second_minute  = pwdata[5:0];
        REG_ON_DURATION_MS: cfg_d.on_duration_ms = pwdata[26:0];
        REG_BUTTON_OUTPUT:  cfg_d.button_output  = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Register read decode.
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_CHANNEL_MODE:   prdata = {29'd0, cfg_q.channel_mode};
      REG_FIRST_HOUR:     prdata = {27'd0, cfg_q.first_hour};
      REG_FIRST_MINUTE:   prdata = {26'd0, cfg_q.first_minute};
      REG_SECOND_HOUR:    prdata = {27'd0, cfg_q.second_hour};
      REG_SECOND_MINUTE:  prdata = {26'd0, cfg_q.second_minute};
      REG_ON_DURATION_MS: prdata = {5'd0, cfg_q.on_duration_ms};
      REG_BUTTON_OUTPUT:  prdata = {31'd0, cfg_q.button_output};
      default:            prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/caot_core.sv =====
module caot_core import caot_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_o
);

  // Pipeline registers.
  logic      s1_valid_q;
  in_item_t  s1_q;
  logic      out_valid_q;
  out_item_t out_q, out_d;

  // Channel state.
  logic        running_q, running_d;
  logic        level_q, level_d;
  logic [31:0] deadline_q, deadline_d;

  logic        s2_ready;
  logic        step;
  logic        first_hit;
  logic        sched_hit;
  logic        now_ge;
  logic        now_gt;
  logic [31:0] add_operand;
  logic [31:0] new_deadline;
  logic        pulse;
  logic        run_mid;

  // Handshake: the output register frees itself when taken, the input
  // register when its item moves on.
  assign s2_ready   = !out_valid_q || out_ready_i;
  assign step       = s1_valid_q && s2_ready;
  assign in_ready_o = !s1_valid_q || s2_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q <= in_i;
    end
  end

  // Schedule match on the calendar fields.
  assign first_hit = (s1_q.hour == cfg_i.first_hour) && (s1_q.minute == cfg_i.first_minute);

  always_comb begin
    case (cfg_i.channel_mode)
      MODE_DAILY:        sched_hit = first_hit;
      MODE_WEEKLY:       sched_hit = first_hit && (s1_q.weekday == Sunday);
      MODE_TWICE_DAILY:  sched_hit = first_hit ||
                                     ((s1_q.hour == cfg_i.second_hour) &&
                                      (s1_q.minute == cfg_i.second_minute));
      MODE_TWICE_WEEKLY: sched_hit = first_hit && ((s1_q.weekday == Sunday) ||
                                                   (s1_q.weekday == SecondWeekday));
      MODE_MONTHLY:      sched_hit = first_hit && (s1_q.day_of_month == FirstDayOfMonth);
      MODE_TWICE_MONTHLY: sched_hit = first_hit &&
                                      ((s1_q.day_of_month == FirstDayOfMonth) ||
                                       (s1_q.day_of_month == SecondDayOfMonth));
      default:           sched_hit = 1'b0;
    endcase
  end

  // One compare serves both deadline tests, one add every new deadline.
  assign now_ge = s1_q.now_ms >= deadline_q;
  assign now_gt = now_ge && (s1_q.now_ms != deadline_q);

  always_comb begin
    if (cfg_i.channel_mode == MODE_ALWAYS_ON) begin
      add_operand = ButtonHoldMs + ButtonGraceMs;
    end else if (cfg_i.button_output) begin
      add_operand = ButtonHoldMs;
    end else begin
      add_operand = {5'd0, cfg_i.on_duration_ms};
    end
  end

  assign new_deadline = s1_q.now_ms + add_operand;

  // Next state and result of the item in the input register.
  always_comb begin
    running_d  = running_q;
    level_d    = level_q;
    deadline_d = deadline_q;
    pulse      = 1'b0;
    run_mid    = running_q;
    if (s1_q.opcode == OP_TOGGLE) begin
      running_d = !running_q;
      if (cfg_i.button_output) begin
        pulse = 1'b1;
      end else begin
        level_d = !running_q;
      end
    end else if (cfg_i.channel_mode == MODE_NONE) begin
      running_d = running_q;
    end else if (cfg_i.channel_mode == MODE_ALWAYS_ON) begin
      if (cfg_i.button_output) begin
        if (!running_q || now_gt) begin
          pulse      = 1'b1;
          running_d  = 1'b1;
          deadline_d = new_deadline;
        end
      end else begin
        level_d = 1'b1;
      end
    end else begin
      // A level channel ends once its deadline is reached.
      if (!cfg_i.button_output && running_q && now_ge) begin
        level_d = 1'b0;
        run_mid = 1'b0;
      end
      running_d = run_mid;
      if (!run_mid && sched_hit) begin
        running_d  = 1'b1;
        deadline_d = new_deadline;
        if (cfg_i.button_output) begin
          pulse = 1'b1;
        end else begin
          level_d = 1'b1;
        end
      end
    end
    out_d.level_out       = level_d;
    out_d.button_pulse    = pulse;
    out_d.channel_running = running_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= 1'b0;
      level_q     <= 1'b0;
      deadline_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s2_ready) begin
        out_valid_q <= s1_valid_q;
      end
      if (step) begin
        running_q  <= running_d;
        level_q    <= level_d;
        deadline_q <= deadline_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // The result register always reports the state that the same item left.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> (out_q.channel_running == running_q) && (out_q.level_out == level_q))
    else $error("result does not match channel state");

  // Only a button channel ever issues a press.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> (!out_q.button_pulse || $past(cfg_i.button_output)))
    else $error("press issued on a level channel");

  // State moves only with an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> $stable(deadline_q) && $stable(running_q) && $stable(level_q))
    else $error("channel state changed without an item");

  // A waiting item in the input register is never dropped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_ready) |=> s1_valid_q)
    else $error("stalled item lost");

endmodule

// ===== hw/rtl/calendar_alarm_output_timer_unit.sv =====
// One calendar alarm output channel. Each tick item carries the free-running
// millisecond clock and the calendar time; a toggle item flips the channel.
// Every item yields exactly one result item with the level, a button press
// flag and the running flag. An item passes an input register and a result
// register in that order, and one item is accepted every cycle while results
// are taken: the whole step is a schedule compare, one 32-bit deadline add
// and one 32-bit compare between the two registers. The user must write
// registers over the APB port only while no item is in flight; the block
// itself does not enforce it.
module calendar_alarm_output_timer_unit import caot_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_o
);

  cfg_t cfg;

  caot_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  caot_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule
